@@ hdl/fmbq_pkg.sv @@
// Shared types and constants for the front/middle/back queue.
// No dependencies; imported by every other file in hdl/.
`default_nettype none

package fmbq_pkg;

	localparam int CAPACITY    = 64;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int CMP_W       = CNT_W + 1;
	localparam int DATA_W      = 32;
	localparam int KIND_W      = 3;
	localparam int HELD_W      = 7;
	localparam int OUT_TDATA_W = ((DATA_W + HELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - HELD_W;
	localparam int OUT_TUSER_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT  = 3'd0,
		KIND_PUSH_MIDDLE = 3'd1,
		KIND_PUSH_BACK   = 3'd2,
		KIND_POP_FRONT   = 3'd3,
		KIND_POP_MIDDLE  = 3'd4,
		KIND_POP_BACK    = 3'd5
	} kind_t;

	// read address relative to the move pointer
	typedef enum logic [2:0] {
		RD_MINUS2,
		RD_MINUS1,
		RD_SAME,
		RD_PLUS1,
		RD_PLUS2
	} rd_off_t;

	typedef struct packed {
		logic    load;
		logic    ptr_init;
		logic    ptr_dec;
		logic    ptr_inc;
		logic    rd_en;
		rd_off_t rd_off;
		logic    mv_wr;
		logic    cap;
		logic    finish;
	} fmbq_cmd_t;

	typedef struct packed {
		logic push_ok;
		logic pop_ok;
		logic push_direct;
		logic last_move;
		logic more1;
		logic more2;
		logic out_free;
	} fmbq_sts_t;

endpackage

`default_nettype wire

@@ hdl/front_middle_back_queue.sv @@
// Top level of the front/middle/back queue: stream ports around ctrl and datapath.
// Depends on fmbq_pkg, fmbq_ctrl and fmbq_dp.
//
// Holds up to CAPACITY (64) signed 32-bit values; each input word pushes or pops at
// the front, the middle or the back and yields one output word. Values live in a
// single memory with one write and one registered read port, so an insert or removal
// moves one entry per cycle. Each op is loaded and decoded; a push that shifts entries
// then reads and moves them one by one, and a pop that finds the queue non-empty reads
// and captures the removed entry, then moves any entries behind it; every op ends in a
// finish step that waits for room at the output. One op is in flight at a time; a
// finished word may wait at the output while the next is taken.
`default_nettype none

module front_middle_back_queue import fmbq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [DATA_W-1:0]      s_axis_tdata,  // [31:0] push_value
	input  logic [KIND_W-1:0]      s_axis_tuser,  // [2:0] kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] pop_value, [38:32] entries_held
	output logic [OUT_TUSER_W-1:0] m_axis_tuser   // [0] was_empty, [1] push_dropped
);

	fmbq_cmd_t         cmd;
	fmbq_sts_t         sts;
	logic [DATA_W-1:0] pop_value;
	logic              was_empty, push_dropped;
	logic [HELD_W-1:0] entries_held;

	fmbq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fmbq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (s_axis_tuser),
		.push_value  (s_axis_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_value   (pop_value),
		.out_empty   (was_empty),
		.out_dropped (push_dropped),
		.out_held    (entries_held)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, entries_held, pop_value};
	assign m_axis_tuser = {push_dropped, was_empty};

endmodule

`default_nettype wire

@@ hdl/fmbq_dp.sv @@
// Datapath: entry memory, count, move pointer and result register.
// Depends on fmbq_pkg; driven by fmbq_ctrl through fmbq_cmd_t.
`default_nettype none

module fmbq_dp import fmbq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [KIND_W-1:0]   kind,
	input  logic [DATA_W-1:0]   push_value,
	input  fmbq_cmd_t           cmd,
	output fmbq_sts_t           sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DATA_W-1:0]   out_value,
	output logic                out_empty,
	output logic                out_dropped,
	output logic [HELD_W-1:0]   out_held
);

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rd_data_q;
	logic [KIND_W-1:0] kind_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_empty_q;
	logic              out_dropped_q;
	logic [HELD_W-1:0] out_held_q;

	logic              is_push, is_pop, full, empty, push_ok, pop_ok;
	logic [CNT_W-1:0]  cnt_dec, pos, next_count;
	logic [CMP_W-1:0]  ptr_ext, count_ext, pos_ext, rd_addr_ext;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              wr_en;

	always_comb begin
		is_push = (kind_q == KIND_PUSH_FRONT) || (kind_q == KIND_PUSH_MIDDLE)
			|| (kind_q == KIND_PUSH_BACK);
		is_pop  = (kind_q == KIND_POP_FRONT) || (kind_q == KIND_POP_MIDDLE)
			|| (kind_q == KIND_POP_BACK);
		full    = count_q == CNT_W'(CAPACITY);
		empty   = count_q == '0;
		push_ok = is_push && !full;
		pop_ok  = is_pop && !empty;
		cnt_dec = count_q - CNT_W'(1);
		unique case (kind_q)
			KIND_PUSH_FRONT:  pos = '0;
			KIND_PUSH_MIDDLE: pos = count_q >> 1;
			KIND_PUSH_BACK:   pos = count_q;
			KIND_POP_FRONT:   pos = '0;
			KIND_POP_MIDDLE:  pos = cnt_dec >> 1;
			KIND_POP_BACK:    pos = cnt_dec;
			default:          pos = '0;
		endcase
		ptr_ext   = CMP_W'(ptr_q);
		count_ext = CMP_W'(count_q);
		pos_ext   = CMP_W'(pos);
	end

	always_comb begin
		sts.push_ok     = push_ok;
		sts.pop_ok      = pop_ok;
		sts.push_direct = pos == count_q;
		sts.last_move   = (ptr_ext - CMP_W'(1)) == pos_ext;
		sts.more1       = (ptr_ext + CMP_W'(1)) < count_ext;
		sts.more2       = (ptr_ext + CMP_W'(2)) < count_ext;
		sts.out_free    = !out_valid_q || out_ready;
	end

	always_comb begin
		unique case (cmd.rd_off)
			RD_MINUS2: rd_addr_ext = ptr_ext - CMP_W'(2);
			RD_MINUS1: rd_addr_ext = ptr_ext - CMP_W'(1);
			RD_SAME:   rd_addr_ext = ptr_ext;
			RD_PLUS1:  rd_addr_ext = ptr_ext + CMP_W'(1);
			RD_PLUS2:  rd_addr_ext = ptr_ext + CMP_W'(2);
			default:   rd_addr_ext = ptr_ext;
		endcase
		rd_addr = rd_addr_ext[ADDR_W-1:0];
		wr_en   = cmd.mv_wr || (cmd.finish && push_ok);
		wr_addr = cmd.mv_wr ? ptr_q : pos[ADDR_W-1:0];
		wr_data = cmd.mv_wr ? rd_data_q : val_q;
		if (cmd.finish && push_ok) begin
			next_count = count_q + CNT_W'(1);
		end else if (cmd.finish && pop_ok) begin
			next_count = cnt_dec;
		end else begin
			next_count = count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			val_q  <= push_value;
		end else if (cmd.cap) begin
			val_q  <= rd_data_q;
		end
		if (cmd.ptr_init) begin
			ptr_q <= push_ok ? count_q[ADDR_W-1:0] : pos[ADDR_W-1:0];
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - ADDR_W'(1);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + ADDR_W'(1);
		end
		if (cmd.finish) begin
			out_value_q   <= pop_ok ? val_q : (is_pop ? '1 : '0);
			out_empty_q   <= is_pop && empty;
			out_dropped_q <= is_push && full;
			out_held_q    <= HELD_W'(next_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= next_count;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign out_empty   = out_empty_q;
	assign out_dropped = out_dropped_q;
	assign out_held    = out_held_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_count_only_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(count_q))
		else $error("count moved outside finish");

	a_finish_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished op produced no word");

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	a_no_move_during_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !cmd.mv_wr)
		else $error("move and finish collide on write port");

endmodule

`default_nettype wire

@@ hdl/fmbq_ctrl.sv @@
// Controller: sequences decode, entry moves and result hand-off.
// Depends on fmbq_pkg; commands fmbq_dp through fmbq_cmd_t.
`default_nettype none

module fmbq_ctrl import fmbq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  fmbq_sts_t sts,
	output fmbq_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PUSH_RD,
		ST_PUSH_MV,
		ST_POP_RD,
		ST_POP_CAP,
		ST_POP_MV,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_off = RD_SAME;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.ptr_init = 1'b1;
				if (sts.push_ok) begin
					state_d = sts.push_direct ? ST_FINISH : ST_PUSH_RD;
				end else if (sts.pop_ok) begin
					state_d = ST_POP_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_PUSH_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_off = RD_MINUS1;
				state_d    = ST_PUSH_MV;
			end
			ST_PUSH_MV: begin
				cmd.mv_wr   = 1'b1;
				cmd.ptr_dec = 1'b1;
				if (sts.last_move) begin
					state_d = ST_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = RD_MINUS2;
				end
			end
			ST_POP_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_POP_CAP;
			end
			ST_POP_CAP: begin
				cmd.cap = 1'b1;
				if (sts.more1) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = RD_PLUS1;
					state_d    = ST_POP_MV;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_POP_MV: begin
				cmd.mv_wr   = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (sts.more2) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = RD_PLUS2;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire
